### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/rfpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpe_pkg
// Panel geometry, field widths, command codes and the RGB565 red/blue swap.
// ----------------------------------------------------------------------------
package rfpe_pkg;

    // panel geometry
    localparam int PANEL_COLUMNS = 800;
    localparam int PANEL_ROWS    = 480;
    localparam int STORE_DEPTH   = PANEL_COLUMNS * PANEL_ROWS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // field widths
    localparam int CRD_W    = 11;
    localparam int DIM_W    = CRD_W + 1;
    localparam int PIX_W    = 16;
    localparam int ORIENT_W = 2;
    localparam int MODE_W   = 2;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 32;

    // geometry constants at working widths
    localparam logic [DIM_W-1:0]  COLS_DIM  = DIM_W'(PANEL_COLUMNS);
    localparam logic [DIM_W-1:0]  ROWS_DIM  = DIM_W'(PANEL_ROWS);
    localparam logic [CRD_W-1:0]  COLS_M1   = CRD_W'(PANEL_COLUMNS - 1);
    localparam logic [CRD_W-1:0]  ROWS_M1   = CRD_W'(PANEL_ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_ADDR = ADDR_W'(PANEL_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // register map
    localparam logic [CFG_AW-1:0] CFG_ORIENT_ADDR = CFG_AW'(0);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_LAND      = 2'd0,
        ORIENT_PORT      = 2'd1,
        ORIENT_LAND_FLIP = 2'd2,
        ORIENT_PORT_FLIP = 2'd3
    } t_orient;

    // exchange the 5-bit red and blue fields of an RGB565 word
    function automatic logic [PIX_W-1:0] swap_rb(input logic [PIX_W-1:0] c);
        return {c[4:0], c[10:5], c[15:11]};
    endfunction

endpackage

### hdl/rfpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpe_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rfpe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered; data updates only while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rotated_framebuffer_pixel_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_framebuffer_pixel_engine
// RGB565 framebuffer with four orientations, point access, fill and clear.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result is
// shown on o_read_color / o_outside for a single cycle with o_done, and the
// receiver must take it then. busy is low in the o_done cycle, so the next
// command may be issued there. Point writes and reads pass the S_GEN,
// S_DRAIN and S_FINISH states; a point outside the visible area or an empty
// fill goes straight to S_FINISH; a fill writes one pixel per cycle through
// the multiply stage and write port; a clear sweeps one store entry per cycle.
// After reset the store is cleared to zero by a sweep of all STORE_DEPTH
// (384000) entries with busy high; orientation writes are taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotated_framebuffer_pixel_engine
    import rfpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command transaction
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CRD_W-1:0]  i_x_coord,
    input  logic [CRD_W-1:0]  i_y_coord,
    input  logic [CRD_W-1:0]  i_x_last,
    input  logic [CRD_W-1:0]  i_y_last,
    input  logic [PIX_W-1:0]  i_pixel_color,
    // result transaction
    output logic              o_done,
    output logic [PIX_W-1:0]  o_read_color,
    output logic              o_outside,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_GEN    = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_FINISH = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_orient            r_orient;
    logic               r_wr_en, n_wr_en;
    logic               r_rd_en, n_rd_en;
    logic               r_outside, n_outside;
    logic               r_sweep_rpt, n_sweep_rpt;
    logic [PIX_W-1:0]   r_color, n_color;
    logic [CRD_W-1:0]   r_x0, n_x0;
    logic [CRD_W-1:0]   r_xe, n_xe;
    logic [CRD_W-1:0]   r_ye, n_ye;
    logic [CRD_W-1:0]   r_cx, n_cx;
    logic [CRD_W-1:0]   r_cy, n_cy;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic               r_p1_vld;
    logic [ADDR_W-1:0]  r_p1_base, n_p1_base;
    logic [CRD_W-1:0]   r_p1_ofs, n_p1_ofs;

    logic               accept;
    t_mode              cmd_mode;
    logic               orient_tall;
    logic [DIM_W-1:0]   vis_w, vis_h;
    logic               pt_in_view;
    logic [CRD_W-1:0]   clip_xe, clip_ye;
    logic               gen_last;
    logic [CRD_W-1:0]   m_idx;
    logic               cfg_wr;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ADDR_W-1:0]  pix_addr;
    logic [PIX_W-1:0]   ram_wdata, ram_rdata;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == CFG_ORIENT_ADDR);
    assign prdata = (paddr == CFG_ORIENT_ADDR)
                  ? {{(CFG_DW-ORIENT_W){1'b0}}, r_orient} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= ORIENT_LAND;
        end else if (cfg_wr) begin
            r_orient <= t_orient'(pwdata[ORIENT_W-1:0]);
        end
    end

    // ---------------- visible area and clipping ----------------
    assign orient_tall = (r_orient == ORIENT_PORT) || (r_orient == ORIENT_PORT_FLIP);
    assign vis_w       = orient_tall ? ROWS_DIM : COLS_DIM;
    assign vis_h       = orient_tall ? COLS_DIM : ROWS_DIM;
    assign pt_in_view  = ({1'b0, i_x_coord} < vis_w) && ({1'b0, i_y_coord} < vis_h);
    assign clip_xe     = ({1'b0, i_x_last} < vis_w) ? i_x_last : CRD_W'(vis_w - 1'b1);
    assign clip_ye     = ({1'b0, i_y_last} < vis_h) ? i_y_last : CRD_W'(vis_h - 1'b1);

    assign cmd_mode = t_mode'(i_mode);
    assign busy     = !((r_state == S_IDLE) || (r_state == S_FINISH));
    assign accept   = start && !busy;
    assign gen_last = (r_cx == r_xe) && (r_cy == r_ye);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_wr_en     = r_wr_en;
        n_rd_en     = r_rd_en;
        n_outside   = r_outside;
        n_sweep_rpt = r_sweep_rpt;
        n_color     = r_color;
        n_x0        = r_x0;
        n_xe        = r_xe;
        n_ye        = r_ye;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_sweep     = r_sweep;

        unique case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            S_GEN: begin
                // raster walk over the clipped rectangle
                if (gen_last) begin
                    n_state = S_DRAIN;
                end else if (r_cx == r_xe) begin
                    n_cx = r_x0;
                    n_cy = r_cy + 1'b1;
                end else begin
                    n_cx = r_cx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_SWEEP: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = r_sweep_rpt ? S_FINISH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // command capture
        if (accept) begin
            n_color     = (cmd_mode == MODE_CLEAR) ? i_pixel_color : swap_rb(i_pixel_color);
            n_wr_en     = (cmd_mode == MODE_WRITE) || (cmd_mode == MODE_FILL);
            n_rd_en     = (cmd_mode == MODE_READ) && pt_in_view;
            n_outside   = ((cmd_mode == MODE_WRITE) || (cmd_mode == MODE_READ)) && !pt_in_view;
            n_sweep_rpt = 1'b1;
            n_sweep     = '0;
            n_x0        = i_x_coord;
            n_cx        = i_x_coord;
            n_cy        = i_y_coord;
            n_xe        = (cmd_mode == MODE_FILL) ? clip_xe : i_x_coord;
            n_ye        = (cmd_mode == MODE_FILL) ? clip_ye : i_y_coord;
            unique case (cmd_mode)
                MODE_WRITE, MODE_READ: begin
                    n_state = pt_in_view ? S_GEN : S_FINISH;
                end
                MODE_FILL: begin
                    n_state = ((i_x_coord > clip_xe) || (i_y_coord > clip_ye))
                            ? S_FINISH : S_GEN;
                end
                MODE_CLEAR: begin
                    n_state = S_SWEEP;
                end
                default: begin
                    n_state = S_FINISH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts a silent zero-fill pass over the store
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_sweep_rpt <= 1'b0;
            r_color     <= '0;
            r_wr_en     <= 1'b0;
            r_rd_en     <= 1'b0;
            r_outside   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_sweep_rpt <= n_sweep_rpt;
            r_color     <= n_color;
            r_wr_en     <= n_wr_en;
            r_rd_en     <= n_rd_en;
            r_outside   <= n_outside;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
        r_xe <= n_xe;
        r_ye <= n_ye;
        r_cx <= n_cx;
        r_cy <= n_cy;
    end

    // ---------------- address stage: addr = COLUMNS * m + ofs ----------------
    always_comb begin
        unique case (r_orient)
            ORIENT_LAND: begin
                m_idx    = r_cy;
                n_p1_ofs = r_cx;
            end
            ORIENT_PORT: begin
                m_idx    = r_cx;
                n_p1_ofs = COLS_M1 - r_cy;
            end
            ORIENT_LAND_FLIP: begin
                m_idx    = ROWS_M1 - r_cy;
                n_p1_ofs = COLS_M1 - r_cx;
            end
            ORIENT_PORT_FLIP: begin
                m_idx    = ROWS_M1 - r_cx;
                n_p1_ofs = r_cy;
            end
            default: begin
                m_idx    = r_cy;
                n_p1_ofs = r_cx;
            end
        endcase
    end

    assign n_p1_base = COLS_ADDR * ADDR_W'(m_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= (r_state == S_GEN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_base <= n_p1_base;
        r_p1_ofs  <= n_p1_ofs;
    end

    // ---------------- frame store ----------------
    assign pix_addr  = r_p1_base + ADDR_W'(r_p1_ofs);
    assign ram_we    = (r_state == S_SWEEP) || (r_p1_vld && r_wr_en);
    assign ram_re    = r_p1_vld && r_rd_en;
    assign ram_addr  = (r_state == S_SWEEP) ? r_sweep : pix_addr;
    assign ram_wdata = r_color;

    rfpe_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (PIX_W),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- result ----------------
    assign o_done       = (r_state == S_FINISH);
    assign o_read_color = r_rd_en ? swap_rb(ram_rdata) : '0;
    assign o_outside    = r_outside;

    // ---------------- assertions ----------------
    `ASSERT_IMPLY(a_rw_excl, i_clk, i_rst_n, ram_we, !ram_re)
    `ASSERT_IMPLY(a_done_drained, i_clk, i_rst_n, o_done, !r_p1_vld)
    `ASSERT_IMPLY(a_read_issued, i_clk, i_rst_n, o_done && r_rd_en, $past(ram_re))
    `ASSERT_IMPLY(a_gen_bounds, i_clk, i_rst_n, r_state == S_GEN, (r_cx <= r_xe) && (r_cy <= r_ye))
    `ASSERT_NEXT(a_drain_done, i_clk, i_rst_n, r_state == S_DRAIN, o_done)

endmodule
